// File: design/txcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package txcw_pkg;

  // Fixed field widths of the channels
  localparam int unsigned DATA_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned POS_W  = 11;

  // Control characters
  localparam logic [DATA_W-1:0] CH_NL    = 8'h0A;
  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;

  // Function codes on the input channel
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Command classes handed from the front end to the executor
  typedef enum logic [2:0] {
    OP_READ,
    OP_CHAR,
    OP_NEWLINE,
    OP_TAB,
    OP_CR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    logic              idx_ok;
  } cmd_t;

  // Executor sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAB,
    ST_FIN,
    ST_SCROLL,
    ST_READ,
    ST_EMIT2
  } state_t;

endpackage

`default_nettype wire

// File: design/txcw_if.sv
// Channel interfaces for the input and result transactions.
`default_nettype none

interface txcw_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [txcw_pkg::DATA_W-1:0]  char_code;
  logic [txcw_pkg::IDX_W-1:0]   cell_index;

  modport source (output valid, output func, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input func, input char_code, input cell_index,
                  output ready);
endinterface

interface txcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [txcw_pkg::DATA_W-1:0]  data_byte;
  logic                         is_serial;
  logic                         last;
  logic [txcw_pkg::POS_W-1:0]   cursor_pos;

  modport source (output valid, output data_byte, output is_serial, output last,
                  output cursor_pos, input ready);
  modport sink   (input valid, input data_byte, input is_serial, input last,
                  input cursor_pos, output ready);
endinterface

`default_nettype wire

// File: design/txcw_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module txcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/txcw_front.sv
// Front end: accepts input transactions and classifies them into commands.
`default_nettype none

module txcw_front #(
  parameter int unsigned CELLS = 2000
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  txcw_in_if.sink              in_if,
  input  wire logic            init_done,
  output logic                 cmd_valid,
  input  wire logic            cmd_ready,
  output txcw_pkg::cmd_t       cmd
);

  localparam int unsigned AW   = $clog2(CELLS);
  localparam int unsigned CMPW = (AW + 1 > txcw_pkg::IDX_W) ? AW + 1 : txcw_pkg::IDX_W;

  logic           valid_r;
  txcw_pkg::cmd_t cmd_r;
  txcw_pkg::cmd_t cls;
  logic           accept;

  // No transaction is taken until the store has been cleared
  assign in_if.ready = init_done && (!valid_r || cmd_ready);
  assign accept      = in_if.valid && in_if.ready;

  // Classify the incoming transaction
  always_comb begin
    cls.char_code  = in_if.char_code;
    cls.cell_index = in_if.cell_index;
    cls.idx_ok     = CMPW'(in_if.cell_index) < CMPW'(CELLS);
    if (in_if.func == txcw_pkg::FUNC_READ) begin
      cls.op = txcw_pkg::OP_READ;
    end else begin
      unique case (in_if.char_code)
        txcw_pkg::CH_NL:  cls.op = txcw_pkg::OP_NEWLINE;
        txcw_pkg::CH_TAB: cls.op = txcw_pkg::OP_TAB;
        txcw_pkg::CH_CR:  cls.op = txcw_pkg::OP_CR;
        default:          cls.op = txcw_pkg::OP_CHAR;
      endcase
    end
  end

  // Command register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (cmd_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cls;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

// File: design/txcw_fifo.sv
// Short command queue between the front end and the executor.
`default_nettype none

module txcw_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire txcw_pkg::cmd_t  push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output txcw_pkg::cmd_t       pop_cmd
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  txcw_pkg::cmd_t  entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count_r != CNTW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: design/txcw_exec.sv
// Executor: cursor tracking, character store, scrolling and the result register.
`default_nettype none

module txcw_exec #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25,
  parameter int unsigned TAB  = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire txcw_pkg::cmd_t  cmd,
  output logic                 init_done,
  txcw_out_if.source           out_if
);

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned LW    = $clog2(CELLS + TAB);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned TMW   = (TAB > 1) ? $clog2(TAB) : 1;
  localparam int unsigned CMT   = COLS % TAB;
  localparam int unsigned DW    = txcw_pkg::DATA_W;

  // Map a logical cell onto the circular store
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] a, input logic [AW-1:0] offs);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, offs};
    if (s >= (AW + 1)'(CELLS)) begin
      s = s - (AW + 1)'(CELLS);
    end
    return s[AW-1:0];
  endfunction

  txcw_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]    lin_r, lin_nxt;       // cursor cell index
  logic [CW-1:0]    col_r, col_nxt;       // cursor column
  logic [TMW-1:0]   colmod_r, colmod_nxt; // column mod TAB
  logic [TMW-1:0]   rowmod_r, rowmod_nxt; // row start mod TAB
  logic [AW-1:0]    toffs_r, toffs_nxt;   // store offset of the top row
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [CW-1:0]    scnt_r, scnt_nxt;
  txcw_pkg::op_t    op_r, op_nxt;
  logic [DW-1:0]    char_r, char_nxt;
  logic             idx_ok_r, idx_ok_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [DW-1:0]               out_data_r, out_data_nxt;
  logic                        out_serial_r, out_serial_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [txcw_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic                        out_free;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;

  // One-cell advance and the TAB phase helpers
  logic [LW-1:0]  st_lin;
  logic [CW-1:0]  st_col;
  logic [TMW-1:0] st_colmod;
  logic [TMW-1:0] st_rowmod;
  logic [TMW-1:0] rm_add;
  logic [TMW-1:0] rm_sub;
  logic [TMW:0]   rm_tmp;
  logic [TMW:0]   phase_sum;
  logic           phase_zero;

  always_comb begin
    rm_tmp = {1'b0, rowmod_r} + (TMW + 1)'(CMT);
    if (rm_tmp >= (TMW + 1)'(TAB)) begin
      rm_tmp = rm_tmp - (TMW + 1)'(TAB);
    end
    rm_add = rm_tmp[TMW-1:0];

    if ({1'b0, rowmod_r} >= (TMW + 1)'(CMT)) begin
      rm_sub = rowmod_r - TMW'(CMT);
    end else begin
      rm_sub = rowmod_r + TMW'(TAB - CMT);
    end

    st_lin = lin_r + 1'b1;
    if (col_r == CW'(COLS - 1)) begin
      st_col    = '0;
      st_colmod = '0;
      st_rowmod = rm_add;
    end else begin
      st_col    = col_r + 1'b1;
      st_colmod = (colmod_r == TMW'(TAB - 1)) ? '0 : colmod_r + 1'b1;
      st_rowmod = rowmod_r;
    end

    phase_sum  = {1'b0, rowmod_r} + {1'b0, colmod_r};
    phase_zero = (phase_sum == '0) || (phase_sum == (TMW + 1)'(TAB));
  end

  assign out_free  = !out_valid_r || out_if.ready;
  assign init_done = state_r != txcw_pkg::ST_CLEAR;

  // Sequencer: next state, store access and result loading
  always_comb begin
    state_nxt      = state_r;
    lin_nxt        = lin_r;
    col_nxt        = col_r;
    colmod_nxt     = colmod_r;
    rowmod_nxt     = rowmod_r;
    toffs_nxt      = toffs_r;
    clr_nxt        = clr_r;
    scnt_nxt       = scnt_r;
    op_nxt         = op_r;
    char_nxt       = char_r;
    idx_ok_nxt     = idx_ok_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_data_nxt   = out_data_r;
    out_serial_nxt = out_serial_r;
    out_last_nxt   = out_last_r;
    out_pos_nxt    = out_pos_r;
    cmd_ready      = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = clr_r;
    wr_data        = txcw_pkg::CH_SPACE;
    rd_en          = 1'b0;
    rd_addr        = phys(AW'(cmd.cell_index), toffs_r);

    unique case (state_r)
      // Fill the whole store with spaces after reset
      txcw_pkg::ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = txcw_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      txcw_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_nxt     = cmd.op;
          char_nxt   = cmd.char_code;
          idx_ok_nxt = cmd.idx_ok;
          unique case (cmd.op)
            txcw_pkg::OP_READ: begin
              rd_en     = 1'b1;
              state_nxt = txcw_pkg::ST_READ;
            end
            txcw_pkg::OP_CHAR: begin
              wr_en      = 1'b1;
              wr_addr    = phys(AW'(lin_r), toffs_r);
              wr_data    = cmd.char_code;
              lin_nxt    = st_lin;
              col_nxt    = st_col;
              colmod_nxt = st_colmod;
              rowmod_nxt = st_rowmod;
              state_nxt  = txcw_pkg::ST_FIN;
            end
            txcw_pkg::OP_NEWLINE: begin
              lin_nxt    = lin_r - LW'(col_r) + LW'(COLS);
              col_nxt    = '0;
              colmod_nxt = '0;
              rowmod_nxt = rm_add;
              state_nxt  = txcw_pkg::ST_FIN;
            end
            txcw_pkg::OP_CR: begin
              lin_nxt    = lin_r - LW'(col_r);
              col_nxt    = '0;
              colmod_nxt = '0;
              state_nxt  = txcw_pkg::ST_FIN;
            end
            txcw_pkg::OP_TAB: begin
              lin_nxt    = st_lin;
              col_nxt    = st_col;
              colmod_nxt = st_colmod;
              rowmod_nxt = st_rowmod;
              state_nxt  = txcw_pkg::ST_TAB;
            end
            default: begin
              state_nxt = txcw_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // Advance one cell a cycle until the next tab stop
      txcw_pkg::ST_TAB: begin
        if (phase_zero) begin
          state_nxt = txcw_pkg::ST_FIN;
        end else begin
          lin_nxt    = st_lin;
          col_nxt    = st_col;
          colmod_nxt = st_colmod;
          rowmod_nxt = st_rowmod;
        end
      end

      // Scroll while the cursor is off the end, then give the first result
      txcw_pkg::ST_FIN: begin
        if (lin_r >= LW'(CELLS)) begin
          scnt_nxt  = '0;
          state_nxt = txcw_pkg::ST_SCROLL;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = char_r;
          out_serial_nxt = 1'b1;
          out_last_nxt   = op_r != txcw_pkg::OP_NEWLINE;
          out_pos_nxt    = txcw_pkg::POS_W'(lin_r);
          state_nxt      = (op_r == txcw_pkg::OP_NEWLINE) ? txcw_pkg::ST_EMIT2
                                                          : txcw_pkg::ST_IDLE;
        end
      end

      // Blank the old top row, which becomes the new bottom row
      txcw_pkg::ST_SCROLL: begin
        wr_en   = 1'b1;
        wr_addr = toffs_r + AW'(scnt_r);
        if (scnt_r == CW'(COLS - 1)) begin
          toffs_nxt  = (toffs_r == AW'(CELLS - COLS)) ? '0 : toffs_r + AW'(COLS);
          lin_nxt    = lin_r - LW'(COLS);
          rowmod_nxt = rm_sub;
          state_nxt  = txcw_pkg::ST_FIN;
        end else begin
          scnt_nxt = scnt_r + 1'b1;
        end
      end

      txcw_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = idx_ok_r ? rd_data : '0;
          out_serial_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          out_pos_nxt    = txcw_pkg::POS_W'(lin_r);
          state_nxt      = txcw_pkg::ST_IDLE;
        end
      end

      // Carriage return that follows a newline
      txcw_pkg::ST_EMIT2: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = txcw_pkg::CH_CR;
          out_serial_nxt = 1'b1;
          out_last_nxt   = 1'b1;
          state_nxt      = txcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = txcw_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= txcw_pkg::ST_CLEAR;
      lin_r       <= '0;
      col_r       <= '0;
      colmod_r    <= '0;
      rowmod_r    <= '0;
      toffs_r     <= '0;
      clr_r       <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lin_r       <= lin_nxt;
      col_r       <= col_nxt;
      colmod_r    <= colmod_nxt;
      rowmod_r    <= rowmod_nxt;
      toffs_r     <= toffs_nxt;
      clr_r       <= clr_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    char_r       <= char_nxt;
    idx_ok_r     <= idx_ok_nxt;
    out_data_r   <= out_data_nxt;
    out_serial_r <= out_serial_nxt;
    out_last_r   <= out_last_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  txcw_ram #(
    .WIDTH (DW),
    .DEPTH (CELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.data_byte  = out_data_r;
  assign out_if.is_serial  = out_serial_r;
  assign out_if.last       = out_last_r;
  assign out_if.cursor_pos = out_pos_r;

endmodule

`default_nettype wire

// File: design/text_console_writer.sv
// Top level of the text console writer.
//
// Input channel in_if: func 0 puts char_code, func 1 reads the cell at
// cell_index. Result channel out_if: data_byte, is_serial, last, cursor_pos.
// A put gives one serial byte (a newline gives 0x0A then 0x0D, last on the
// second); a read gives one byte with is_serial low, 0 for a cell off the store.
// Transactions pass a classify register and a short queue before the executor,
// so the front keeps taking input while a result waits on a stalled receiver.
// Transactions pass the classify register, the queue and the FIN or READ
// state before a result is registered. The executor sequencer sets the rate: it
// takes a new command only when idle, after loading the last result of the
// previous one; a tab advances cell by cell to the next tab stop, at most TAB
// cells, and a scroll blanks the old top row. Scrolling is a moving top-row
// offset into the store, so no rows are copied. After reset the store is
// cleared to spaces, during which in_if.ready stays low. When out_if.ready is
// low the result register holds and the queue fills, then in_if.ready drops.
`default_nettype none

module text_console_writer #(
  parameter int unsigned COLS   = 80,
  parameter int unsigned ROWS   = 25,
  parameter int unsigned TAB    = 4,
  parameter int unsigned QDEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  txcw_in_if.sink      in_if,
  txcw_out_if.source   out_if
);

  logic           init_done;
  logic           fr_valid;
  logic           fr_ready;
  txcw_pkg::cmd_t fr_cmd;
  logic           q_valid;
  logic           q_ready;
  txcw_pkg::cmd_t q_cmd;

  txcw_front #(
    .CELLS (COLS * ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .init_done (init_done),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  txcw_fifo #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_cmd   (fr_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  txcw_exec #(
    .COLS (COLS),
    .ROWS (ROWS),
    .TAB  (TAB)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .init_done (init_done),
    .out_if    (out_if)
  );

endmodule

`default_nettype wire

// File: design/txcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
`default_nettype none

module txcw_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [txcw_pkg::DATA_W-1:0]       out_data_byte,
  input wire logic                              out_is_serial,
  input wire logic                              out_last,
  input wire logic [txcw_pkg::POS_W-1:0]        out_cursor_pos
);

  // Clearing pass follows reset, so nothing is taken straight after it
  a_no_input_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted during the clearing pass");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
      $stable(out_is_serial) && $stable(out_last) && $stable(out_cursor_pos))
    else $error("result changed while stalled");

  // Read data always ends its transaction
  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_serial |-> out_last)
    else $error("read result not marked last");

  // Only a newline leads a pair of results
  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_is_serial && out_data_byte == txcw_pkg::CH_NL)
    else $error("non-final result is not a newline");

  // The carriage return follows at once with the same cursor
  a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last &&
      out_is_serial && out_data_byte == txcw_pkg::CH_CR && $stable(out_cursor_pos))
    else $error("newline not followed by carriage return");

endmodule

bind text_console_writer txcw_checker u_txcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_data_byte  (out_if.data_byte),
  .out_is_serial  (out_if.is_serial),
  .out_last       (out_if.last),
  .out_cursor_pos (out_if.cursor_pos)
);

`default_nettype wire
